// ===== sv/wfd_pkg.sv =====
package wfd_pkg;

    localparam int HIST_LEN    = 20;
    localparam int BASE_WEIGHT = 40;
    localparam int NEW_WEIGHT  = BASE_WEIGHT + HIST_LEN - 1;

    localparam int STATE_W = 2;
    localparam int MASK_W  = 4;
    localparam int THR_W   = 10;
    localparam int SUM_W   = 10;
    localparam int CNT_W   = $clog2(HIST_LEN + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [THR_W-1:0] THR_LOW_RESET  = THR_W'(250);
    localparam logic [THR_W-1:0] THR_HIGH_RESET = THR_W'(300);

    typedef enum logic [1:0] {
        REG_THR_LOW  = 2'd0,
        REG_THR_HIGH = 2'd1,
        REG_IGNORE   = 2'd2,
        REG_ENABLE   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [THR_W-1:0]  thr_low;
        logic [THR_W-1:0]  thr_high;
        logic [MASK_W-1:0] ignore_mask;
        logic              detect_enable;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] flap_value_tenths;
        logic             flap_flag;
        logic             flap_changed;
        logic             notify_change;
        logic             reported_flapping;
    } result_t;

endpackage

// ===== sv/wfd_in_if.sv =====
interface wfd_in_if
    import wfd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] new_state;

    modport source (output valid, output new_state, input ready);
    modport sink (input valid, input new_state, output ready);
endinterface

// ===== sv/wfd_out_if.sv =====
interface wfd_out_if
    import wfd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] flap_value_tenths;
    logic             flap_flag;
    logic             flap_changed;
    logic             notify_change;
    logic             reported_flapping;

    modport source (
        output valid, output flap_value_tenths, output flap_flag, output flap_changed,
        output notify_change, output reported_flapping, input ready
    );
    modport sink (
        input valid, input flap_value_tenths, input flap_flag, input flap_changed,
        input notify_change, input reported_flapping, output ready
    );
endinterface

// ===== sv/weighted_flap_detector_core.sv =====
// Channel     | Direction | Payload
// ------------+-----------+---------------------------------------------------
// state_item  | in        | new_state
// flap_item   | out       | flap_value_tenths, flap_flag, flap_changed,
//             |           | notify_change, reported_flapping
// APB         | in/out    | threshold_low, threshold_high, ignore_mask, enable
//
// One item per cycle while ready is high; results are registered to flap_item.
// The history sum is updated incrementally as the chain of cells shifts.
// An output register and a skid entry let an item be accepted while a result waits.
// state_item.ready is low only while the skid entry is full.
// Reset clears the history, last kept state, flapping state and valid flags.
module weighted_flap_detector_core
    import wfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    wfd_in_if.sink                state_item,
    wfd_out_if.source             flap_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t               cfg;
    logic               in_fire;
    logic               out_fire;
    logic               ignored;
    logic               change_bit;
    logic [SUM_W-1:0]   value_next;
    logic               flag;
    result_t            res;

    logic [STATE_W-1:0] last_state_reg;
    logic [STATE_W-1:0] last_state_next;
    logic               flapping_reg;
    logic               flapping_next;
    result_t            out_reg;
    result_t            out_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            skid_reg;
    result_t            skid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;

    wfd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wfd_history u_history (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (in_fire),
        .change_bit (change_bit),
        .value_next (value_next)
    );

    assign state_item.ready = !skid_valid_reg;
    assign in_fire          = state_item.valid && !skid_valid_reg;
    assign out_fire         = out_valid_reg && flap_item.ready;

    assign ignored    = cfg.ignore_mask[state_item.new_state];
    assign change_bit = !ignored && (state_item.new_state != last_state_reg);

    always_comb
    begin
        flag = flapping_reg ? (value_next > cfg.thr_low) : (value_next > cfg.thr_high);
        res.flap_value_tenths = value_next;
        res.flap_flag         = flag;
        res.flap_changed      = flag != flapping_reg;
        res.notify_change     = (flag != flapping_reg) && cfg.detect_enable;
        res.reported_flapping = flag && cfg.detect_enable;
    end

    always_comb
    begin
        last_state_next = last_state_reg;
        flapping_next   = flapping_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (in_fire)
        begin
            if (!ignored)
            begin
                last_state_next = state_item.new_state;
            end
            flapping_next = flag;
            if (!out_valid_reg || flap_item.ready)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_state_reg <= '0;
            flapping_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            last_state_reg <= last_state_next;
            flapping_reg   <= flapping_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign flap_item.valid             = out_valid_reg;
    assign flap_item.flap_value_tenths = out_reg.flap_value_tenths;
    assign flap_item.flap_flag         = out_reg.flap_flag;
    assign flap_item.flap_changed      = out_reg.flap_changed;
    assign flap_item.notify_change     = out_reg.notify_change;
    assign flap_item.reported_flapping = out_reg.reported_flapping;

endmodule

// ===== sv/wfd_cell.sv =====
module wfd_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic shift,
    input  logic bit_in,
    output logic bit_out
);

    logic bit_reg;
    logic bit_next;

    assign bit_next = shift ? bit_in : bit_reg;
    assign bit_out  = bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

endmodule

// ===== sv/wfd_history.sv =====
module wfd_history
    import wfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic             change_bit,
    output logic [SUM_W-1:0] value_next
);

    // Cell 0 holds the oldest change mark, the last cell the newest.
    logic [HIST_LEN-1:0] taps;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [SUM_W-1:0]    add_new;
    logic [SUM_W-1:0]    drop_old;

    for (genvar r = 0; r < HIST_LEN; r++)
    begin : g_cell
        if (r == HIST_LEN - 1)
        begin : g_last
            wfd_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .bit_in  (change_bit),
                .bit_out (taps[r])
            );
        end
        else
        begin : g_mid
            wfd_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .bit_in  (taps[r+1]),
                .bit_out (taps[r])
            );
        end
    end

    // Every kept mark moves one rank down and loses one from its weight; the
    // oldest mark leaves with its base weight and the new one enters at the top.
    assign add_new    = change_bit ? SUM_W'(NEW_WEIGHT) : '0;
    assign drop_old   = taps[0] ? SUM_W'(BASE_WEIGHT) : '0;
    assign value_next = sum_reg + add_new + SUM_W'(taps[0]) - SUM_W'(cnt_reg) - drop_old;
    assign sum_next   = shift ? value_next : sum_reg;
    assign cnt_next   = shift ? (cnt_reg + CNT_W'(change_bit) - CNT_W'(taps[0])) : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== sv/wfd_cfg.sv =====
module wfd_cfg
    import wfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_THR_LOW:  cfg_next.thr_low       = pwdata[THR_W-1:0];
                REG_THR_HIGH: cfg_next.thr_high      = pwdata[THR_W-1:0];
                REG_IGNORE:   cfg_next.ignore_mask   = pwdata[MASK_W-1:0];
                REG_ENABLE:   cfg_next.detect_enable = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_THR_LOW:  prdata = APB_DATA_W'(cfg_reg.thr_low);
            REG_THR_HIGH: prdata = APB_DATA_W'(cfg_reg.thr_high);
            REG_IGNORE:   prdata = APB_DATA_W'(cfg_reg.ignore_mask);
            REG_ENABLE:   prdata = APB_DATA_W'(cfg_reg.detect_enable);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thr_low       <= THR_LOW_RESET;
            cfg_reg.thr_high      <= THR_HIGH_RESET;
            cfg_reg.ignore_mask   <= '0;
            cfg_reg.detect_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/wfd_checker.sv =====
module wfd_checker
    import wfd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [SUM_W-1:0] flap_value_tenths,
    input logic             flap_flag,
    input logic             flap_changed,
    input logic             notify_change,
    input logic             reported_flapping
);

    // An accepted item always leaves a result pending on the next cycle.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted item produced no pending result");

    a_notify_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && notify_change) |-> flap_changed)
        else $error("notify_change without flap_changed");

    a_report_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reported_flapping) |-> flap_flag)
        else $error("reported_flapping without flap_flag");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (flap_value_tenths <= SUM_W'(990)))
        else $error("flap value out of range");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(flap_value_tenths)))
        else $error("stalled result dropped or changed");

endmodule

bind weighted_flap_detector_core wfd_checker u_wfd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (state_item.valid),
    .in_ready          (state_item.ready),
    .out_valid         (flap_item.valid),
    .out_ready         (flap_item.ready),
    .flap_value_tenths (flap_item.flap_value_tenths),
    .flap_flag         (flap_item.flap_flag),
    .flap_changed      (flap_item.flap_changed),
    .notify_change     (flap_item.notify_change),
    .reported_flapping (flap_item.reported_flapping)
);
